[rtl/pprn_pkg.sv]
`default_nettype none
package pprn_pkg;

  localparam int COORD_BITS = 11;
  localparam int FOCAL_BITS = 13;
  localparam int FRAC_BITS  = 15;

  // widest lane magnitude, sum of squares, and the partial product width
  localparam int MAG_BITS = (COORD_BITS > FOCAL_BITS) ? COORD_BITS : FOCAL_BITS;
  localparam int SUM_BITS = 2 * MAG_BITS + 2;
  localparam int ACC_BITS = 2 * FRAC_BITS + SUM_BITS + 1;
  localparam int QS_BITS  = FRAC_BITS + SUM_BITS;

  localparam int LANES = 3;

  // register indexes
  localparam logic [1:0] REG_CENTER_COL = 2'd0;
  localparam logic [1:0] REG_CENTER_ROW = 2'd1;
  localparam logic [1:0] REG_FOCAL      = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic signed [FRAC_BITS:0] ray_x;
    logic signed [FRAC_BITS:0] ray_y;
    logic [FRAC_BITS-1:0]      ray_z;
  } ray_t;

  // per word flags that ride along the cell chain
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [LANES-1:0] neg;
  } tag_t;

endpackage
`default_nettype wire

[rtl/pprn_cell.sv]
`default_nettype none
// One result bit for all three lanes: trial t = q | 2^BIT, tested as
// q^2*S + q*S*2^(BIT+1) + S*2^(2*BIT) <= target, all kept incrementally.
module pprn_cell #(
  parameter int BIT = 0
) (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        en,
  input  wire pprn_pkg::tag_t                        tag_i,
  input  wire [pprn_pkg::LANES-1:0][pprn_pkg::SUM_BITS-1:0]  s_i,
  input  wire [pprn_pkg::LANES-1:0][pprn_pkg::ACC_BITS-1:0]  tgt_i,
  input  wire [pprn_pkg::LANES-1:0][pprn_pkg::ACC_BITS-1:0]  p_i,
  input  wire [pprn_pkg::LANES-1:0][pprn_pkg::QS_BITS-1:0]   qs_i,
  input  wire [pprn_pkg::LANES-1:0][pprn_pkg::FRAC_BITS-1:0] q_i,
  output pprn_pkg::tag_t                             tag_o,
  output logic [pprn_pkg::LANES-1:0][pprn_pkg::SUM_BITS-1:0]  s_o,
  output logic [pprn_pkg::LANES-1:0][pprn_pkg::ACC_BITS-1:0]  tgt_o,
  output logic [pprn_pkg::LANES-1:0][pprn_pkg::ACC_BITS-1:0]  p_o,
  output logic [pprn_pkg::LANES-1:0][pprn_pkg::QS_BITS-1:0]   qs_o,
  output logic [pprn_pkg::LANES-1:0][pprn_pkg::FRAC_BITS-1:0] q_o
);
  import pprn_pkg::*;

  logic [LANES-1:0][ACC_BITS-1:0]  p_next;
  logic [LANES-1:0][QS_BITS-1:0]   qs_next;
  logic [LANES-1:0][FRAC_BITS-1:0] q_next;

  // trial and accept per lane
  always_comb begin
    logic [ACC_BITS-1:0] cand;
    for (int l = 0; l < LANES; l++) begin
      cand = p_i[l] + (ACC_BITS'(qs_i[l]) << (BIT + 1)) + (ACC_BITS'(s_i[l]) << (2 * BIT));
      if (cand <= tgt_i[l]) begin
        p_next[l]  = cand;
        qs_next[l] = qs_i[l] + (QS_BITS'(s_i[l]) << BIT);
        q_next[l]  = q_i[l] | (FRAC_BITS'(1) << BIT);
      end else begin
        p_next[l]  = p_i[l];
        qs_next[l] = qs_i[l];
        q_next[l]  = q_i[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else if (en) begin
      tag_o.valid <= tag_i.valid;
    end
    if (en) begin
      tag_o.zero <= tag_i.zero;
      tag_o.neg  <= tag_i.neg;
      s_o        <= s_i;
      tgt_o      <= tgt_i;
      p_o        <= p_next;
      qs_o       <= qs_next;
      q_o        <= q_next;
    end
  end

endmodule
`default_nettype wire

[rtl/pinhole_pixel_ray_normalizer_top.sv]
`default_nettype none
// Registers from in word to out word: stages 1 to 3, the cell chain and the output register; x and y leave as Q1.15.
// Throughput: one word per cycle; a stall at out_ready halts the whole chain.
// One cell per result bit, all three components side by side in each cell.
// Reset (rst, synchronous): pipeline emptied, registers back to
// center_col 320, center_row 240, focal_pixels 500.
module pinhole_pixel_ray_normalizer_top (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire pprn_pkg::pixel_t          in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output pprn_pkg::ray_t                 out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [1:0]                      cfg_index,
  input  wire [pprn_pkg::FOCAL_BITS-1:0] cfg_data
);
  import pprn_pkg::*;

  logic [COORD_BITS-1:0] center_col;
  logic [COORD_BITS-1:0] center_row;
  logic [FOCAL_BITS-1:0] focal_pixels;

  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_col   <= COORD_BITS'(320);
      center_row   <= COORD_BITS'(240);
      focal_pixels <= FOCAL_BITS'(500);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_COL: center_col   <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_ROW: center_row   <= cfg_data[COORD_BITS-1:0];
        REG_FOCAL:      focal_pixels <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: offsets from the principal point, split into sign and magnitude
  logic                            v1;
  logic [LANES-1:0]                neg1;
  logic [LANES-1:0][MAG_BITS-1:0]  mag1;
  logic signed [COORD_BITS:0]      dx, dy;

  always_comb begin
    dx = $signed({1'b0, in_data.pixel_col}) - $signed({1'b0, center_col});
    dy = $signed({1'b0, in_data.pixel_row}) - $signed({1'b0, center_row});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1    <= {1'b0, dy[COORD_BITS], dx[COORD_BITS]};
      mag1[0] <= MAG_BITS'(dx[COORD_BITS] ? -dx : dx);
      mag1[1] <= MAG_BITS'(dy[COORD_BITS] ? -dy : dy);
      mag1[2] <= MAG_BITS'(focal_pixels);
    end
  end

  // stage 2: squares
  logic                              v2;
  logic [LANES-1:0]                  neg2;
  logic [LANES-1:0][2*MAG_BITS-1:0]  sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      for (int l = 0; l < LANES; l++) begin
        sq2[l] <= mag1[l] * mag1[l];
      end
    end
  end

  // stage 3: sum of squares and per-lane targets, head of the cell chain
  tag_t                           tag3;
  logic [LANES-1:0][SUM_BITS-1:0] s3;
  logic [LANES-1:0][ACC_BITS-1:0] tgt3;
  logic [SUM_BITS-1:0]            sum2;

  assign sum2 = SUM_BITS'(sq2[0]) + SUM_BITS'(sq2[1]) + SUM_BITS'(sq2[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3.valid <= 1'b0;
    end else if (en) begin
      tag3.valid <= v2;
    end
    if (en) begin
      tag3.zero <= (sum2 == '0);
      tag3.neg  <= neg2;
      for (int l = 0; l < LANES; l++) begin
        s3[l]   <= sum2;
        tgt3[l] <= ACC_BITS'(sq2[l]) << (2 * FRAC_BITS);
      end
    end
  end

  // cell chain, most significant result bit first
  tag_t                            tag_c [FRAC_BITS+1];
  logic [LANES-1:0][SUM_BITS-1:0]  s_c   [FRAC_BITS+1];
  logic [LANES-1:0][ACC_BITS-1:0]  tgt_c [FRAC_BITS+1];
  logic [LANES-1:0][ACC_BITS-1:0]  p_c   [FRAC_BITS+1];
  logic [LANES-1:0][QS_BITS-1:0]   qs_c  [FRAC_BITS+1];
  logic [LANES-1:0][FRAC_BITS-1:0] q_c   [FRAC_BITS+1];

  assign tag_c[0] = tag3;
  assign s_c[0]   = s3;
  assign tgt_c[0] = tgt3;
  assign p_c[0]   = '0;
  assign qs_c[0]  = '0;
  assign q_c[0]   = '0;

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
    pprn_cell #(.BIT(FRAC_BITS - 1 - k)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .tag_i (tag_c[k]),
      .s_i   (s_c[k]),
      .tgt_i (tgt_c[k]),
      .p_i   (p_c[k]),
      .qs_i  (qs_c[k]),
      .q_i   (q_c[k]),
      .tag_o (tag_c[k+1]),
      .s_o   (s_c[k+1]),
      .tgt_o (tgt_c[k+1]),
      .p_o   (p_c[k+1]),
      .qs_o  (qs_c[k+1]),
      .q_o   (q_c[k+1])
    );
  end

  // output register: signs applied, degenerate ray forced straight ahead
  tag_t                            tag_e;
  logic [LANES-1:0][FRAC_BITS-1:0] q_e;
  assign tag_e = tag_c[FRAC_BITS];
  assign q_e   = q_c[FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tag_e.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tag_e.zero) begin
        out_data.ray_x <= '0;
        out_data.ray_y <= '0;
        out_data.ray_z <= '1;
      end else begin
        out_data.ray_x <= tag_e.neg[0] ? -$signed({1'b0, q_e[0]}) : $signed({1'b0, q_e[0]});
        out_data.ray_y <= tag_e.neg[1] ? -$signed({1'b0, q_e[1]}) : $signed({1'b0, q_e[1]});
        out_data.ray_z <= q_e[2];
      end
    end
  end

  // checks
  a_no_min_x: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.ray_x != {1'b1, {FRAC_BITS{1'b0}}})
    else $error("ray_x reached the negative limit");
  a_no_min_y: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.ray_y != {1'b1, {FRAC_BITS{1'b0}}})
    else $error("ray_y reached the negative limit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while chain is stalled");

endmodule
`default_nettype wire

[tb/pinhole_pixel_ray_normalizer_top_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module pinhole_pixel_ray_normalizer_top_test;
  import pprn_pkg::*;

  localparam int DRAIN_CYCLES = 30;
  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pixel_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ray_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_CENTER_COL;
  logic [FOCAL_BITS-1:0] cfg_data = '0;

  pinhole_pixel_ray_normalizer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // camera model copy
  logic [COORD_BITS-1:0] cam_cx = 11'd320;
  logic [COORD_BITS-1:0] cam_cy = 11'd240;
  logic [FOCAL_BITS-1:0] cam_f = 13'd500;

  pixel_t pixel_q[$];
  ray_t ray_expect[$];
  int errors = 0;
  int rays_checked = 0;
  int cfg_writes = 0;
  bit idle_on = 1'b1;
  bit src_pause = 1'b0;
  int sink_hold = 0;
  int src_gap = 0;
  int sink_gap = 0;

  // largest q < 2^FRAC_BITS with q^2 * s <= mag^2 * 2^(2*FRAC_BITS)
  function automatic logic [FRAC_BITS-1:0] unit_len(logic [127:0] mag, logic [127:0] s);
    logic [127:0] target;
    logic [127:0] t;
    logic [FRAC_BITS-1:0] q;
    target = (mag * mag) << (2 * FRAC_BITS);
    q = '0;
    for (int b = FRAC_BITS - 1; b >= 0; b--) begin
      t = 128'(q) | (128'd1 << b);
      if (t * t * s <= target) q = t[FRAC_BITS-1:0];
    end
    return q;
  endfunction

  function automatic ray_t predict_ray(pixel_t p);
    longint dx, dy;
    logic [127:0] s;
    logic [FRAC_BITS-1:0] mx, my;
    ray_t r;
    dx = longint'(p.pixel_col) - longint'(cam_cx);
    dy = longint'(p.pixel_row) - longint'(cam_cy);
    s = 128'(dx * dx) + 128'(dy * dy) + 128'(cam_f) * 128'(cam_f);
    if (s == 0) begin
      r.ray_x = '0;
      r.ray_y = '0;
      r.ray_z = '1;
      return r;
    end
    mx = unit_len(128'(dx < 0 ? -dx : dx), s);
    my = unit_len(128'(dy < 0 ? -dy : dy), s);
    r.ray_x = dx < 0 ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    r.ray_y = dy < 0 ? -$signed({1'b0, my}) : $signed({1'b0, my});
    r.ray_z = unit_len(128'(cam_f), s);
    return r;
  endfunction

  // driver: offers queued pixel words, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) ray_expect.push_back(predict_ray(in_data));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0 && !src_pause) begin
          in_valid <= 1'b1;
          in_data <= pixel_q.pop_front();
          if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks ray words and throttles out_ready
  always @(posedge clk) begin
    ray_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (ray_expect.size() == 0) begin
          $display("%0t: unexpected ray word %h", $time, out_data);
          errors++;
        end else begin
          want = ray_expect.pop_front();
          rays_checked++;
          if (out_data.ray_x !== want.ray_x)
            $display("%0t: ray_x expected %0d actual %0d", $time, want.ray_x, out_data.ray_x);
          if (out_data.ray_y !== want.ray_y)
            $display("%0t: ray_y expected %0d actual %0d", $time, want.ray_y, out_data.ray_y);
          if (out_data.ray_z !== want.ray_z)
            $display("%0t: ray_z expected %0d actual %0d", $time, want.ray_z, out_data.ray_z);
          if (out_data !== want) errors++;
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [FOCAL_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_CENTER_COL: cam_cx = value[COORD_BITS-1:0];
      REG_CENTER_ROW: cam_cy = value[COORD_BITS-1:0];
      REG_FOCAL:      cam_f = value;
      default: ;
    endcase
  endtask

  task automatic set_camera(int cx, int cy, int f);
    write_reg(REG_CENTER_COL, FOCAL_BITS'(cx) | (FOCAL_BITS'($urandom_range(0, 3)) << 11));
    write_reg(REG_CENTER_ROW, FOCAL_BITS'(cy) | (FOCAL_BITS'($urandom_range(0, 3)) << 11));
    write_reg(REG_FOCAL, FOCAL_BITS'(f));
    // index past the last register is ignored
    write_reg(REG_UNUSED, FOCAL_BITS'($urandom));
  endtask

  task automatic drain();
    @(posedge clk);
    while (pixel_q.size() > 0 || in_valid || ray_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(int c, int r);
    pixel_t p;
    p.pixel_col = COORD_BITS'(c);
    p.pixel_row = COORD_BITS'(r);
    pixel_q.push_back(p);
  endtask

  // mostly spread over the frame, some hugging the principal point
  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: push_pixel(int'(cam_cx) + $urandom_range(0, 8) - 4,
                      int'(cam_cy) + $urandom_range(0, 8) - 4);
        1: push_pixel($urandom_range(0, 1) * 2047, $urandom_range(0, 2047));
        default: push_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
      endcase
    end
  endtask

  initial begin
    int f;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset camera: center, corners, axes
    push_pixel(320, 240); push_pixel(0, 0); push_pixel(2047, 2047);
    push_pixel(0, 2047); push_pixel(2047, 0); push_pixel(320, 0); push_pixel(0, 240);
    drain();

    // zero focal length: degenerate ray and unit in-plane components
    set_camera(100, 200, 0);
    push_pixel(100, 200); push_pixel(100, 0); push_pixel(0, 200);
    push_pixel(2047, 200); push_pixel(100, 2047); push_pixel(2047, 2047);
    drain();

    // longest focal length, unit forward ray
    set_camera(0, 2047, 8191);
    push_pixel(0, 2047); push_pixel(2047, 0); push_pixel(1, 2046); push_pixel(1365, 682);
    drain();

    set_camera(2047, 0, 1);
    push_pixel(2047, 0); push_pixel(0, 2047); push_pixel(2046, 1); push_pixel(2047, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: f = 0;
        1: f = $urandom_range(1, 16);
        2: f = $urandom_range(8000, 8191);
        default: f = $urandom_range(1, 8191);
      endcase
      set_camera($urandom_range(0, 2047), $urandom_range(0, 2047), f);
      if (ph == 5) idle_on = 1'b0;
      if (ph == 1) sink_hold = 300;
      push_random(40);
      if (ph == 2) begin
        // sender holds back until the pipeline is empty
        src_pause = 1'b1;
        @(posedge clk);
        while (ray_expect.size() > 0 || in_valid) @(posedge clk);
        src_pause = 1'b0;
      end
      push_random(40);
      drain();
    end

    $display("Checked %0d rays over %0d register writes, with stalls and a long hold-off.",
             rays_checked, cfg_writes);
    if (errors == 0 && ray_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/pprn_pkg.sv
rtl/pprn_cell.sv
rtl/pinhole_pixel_ray_normalizer_top.sv
tb/pinhole_pixel_ray_normalizer_top_test.sv
